// ----- sv/ysq_pkg.sv -----
// types and constants shared by the yaml scalar quote classifier
// no dependencies; used by ysq_num_fsm and yaml_scalar_quote_classifier
package ysq_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
    logic       empty_scalar;
  } in_item_t;

  typedef struct packed {
    logic       needs_quote;
    logic [3:0] reason;
  } out_item_t;

  // result reason codes, in priority order
  localparam logic [3:0] REASON_PLAIN       = 4'd0;
  localparam logic [3:0] REASON_EMPTY       = 4'd1;
  localparam logic [3:0] REASON_BREAK       = 4'd2;
  localparam logic [3:0] REASON_EDGE_SPACE  = 4'd3;
  localparam logic [3:0] REASON_INDICATOR   = 4'd4;
  localparam logic [3:0] REASON_COLON_SPACE = 4'd5;
  localparam logic [3:0] REASON_TILDE       = 4'd6;
  localparam logic [3:0] REASON_WORD        = 4'd7;
  localparam logic [3:0] REASON_NUMERIC     = 4'd8;

  // numeric literal recognizer states
  localparam int unsigned NUM_W = 5;
  localparam logic [NUM_W-1:0] NS_START   = 5'd0;
  localparam logic [NUM_W-1:0] NS_SIGN    = 5'd1;
  localparam logic [NUM_W-1:0] NS_ZERO    = 5'd2;
  localparam logic [NUM_W-1:0] NS_INT     = 5'd3;
  localparam logic [NUM_W-1:0] NS_DOTONLY = 5'd4;
  localparam logic [NUM_W-1:0] NS_FRAC    = 5'd5;
  localparam logic [NUM_W-1:0] NS_EXPE    = 5'd6;
  localparam logic [NUM_W-1:0] NS_EXPSIGN = 5'd7;
  localparam logic [NUM_W-1:0] NS_EXPDIG  = 5'd8;
  localparam logic [NUM_W-1:0] NS_HEXPRE  = 5'd9;
  localparam logic [NUM_W-1:0] NS_HEX     = 5'd10;
  localparam logic [NUM_W-1:0] NS_OCTPRE  = 5'd11;
  localparam logic [NUM_W-1:0] NS_OCT     = 5'd12;
  localparam logic [NUM_W-1:0] NS_DEAD    = 5'd13;

  // head window depth and saturating length limit
  localparam int unsigned HEAD_DEPTH = 5;
  localparam logic [2:0]  CNT_MAX    = 3'd6;

  typedef struct packed {
    logic [NUM_W-1:0] next_state;
    logic             accepting;
  } num_status_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

// ----- sv/yaml_scalar_quote_classifier.sv -----
// top level of the yaml plain scalar quoting classifier
// depends on ysq_pkg and ysq_num_fsm
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) carries one byte of a
//   scalar per transfer, the final byte flagged by last; a zero-length scalar
//   is one transfer with empty_scalar set (any bytes already taken are dropped)
//   output channel (out_valid_o / out_stall_i / out_data_o) carries one result
//   per scalar: needs_quote and the first reason that applies
// path: an item taken sits in the input register; its result is then written
//   to the output register (out_valid_o high then)
// throughput: one item per cycle while no stall holds the input; the whole
//   per-byte update and the end-of-scalar classification are combinational
//   between the input register and the output register
// stall: while out_stall_i holds a result, bytes without last still flow in;
//   an item that ends a scalar waits in the input register and in_stall_o
//   rises until the output register frees, while that item sits there
// reset: all valid flags clear, the scalar state returns to empty, and the
//   recognizer goes to its start state; no result is pending
module yaml_scalar_quote_classifier (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ysq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ysq_pkg::out_item_t out_data_o
);

  // input register
  logic              in_valid_q;
  ysq_pkg::in_item_t in_q;

  // output register
  logic               out_valid_q;
  ysq_pkg::out_item_t out_q;

  // scalar state
  logic [ysq_pkg::HEAD_DEPTH-1:0][7:0] head_q, head_d;
  logic [2:0]                          cnt_q, cnt_d;
  logic [7:0]                          prev_q;
  logic                                break_q, break_d;
  logic                                colon_q, colon_d;
  logic [ysq_pkg::NUM_W-1:0]           num_q;

  logic                 produces;
  logic                 advance;
  logic                 out_free;
  logic [7:0]           b;
  logic [7:0]           fb;
  logic [7:0]           first;
  logic                 first_ws;
  logic                 last_ws;
  logic                 first_ind;
  logic                 first_sign;
  logic                 is_word;
  logic                 is_special_num;
  logic [3:0]           reason;
  ysq_pkg::num_status_t num_status;

  // ---------------------------------------------------------------------
  // handshake: an item ending a scalar needs the output register
  // ---------------------------------------------------------------------
  assign produces   = in_q.last || in_q.empty_scalar;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!produces || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // per-byte state update
  // ---------------------------------------------------------------------
  assign b  = in_q.char_byte;
  assign fb = ysq_pkg::fold(b);

  ysq_num_fsm u_num_fsm (
    .state_i  (num_q),
    .char_i   (b),
    .status_o (num_status)
  );

  always_comb begin
    head_d = head_q;
    for (int i = 0; i < ysq_pkg::HEAD_DEPTH; i++) begin
      if (cnt_q == 3'(i)) begin
        head_d[i] = fb;
      end
    end
  end

  assign cnt_d   = (cnt_q < ysq_pkg::CNT_MAX) ? cnt_q + 3'd1 : cnt_q;
  assign break_d = break_q || (b == 8'h0a) || (b == 8'h0d);
  assign colon_d = colon_q || ((cnt_q != 3'd0) && (prev_q == ":") && (b == " "));

  // ---------------------------------------------------------------------
  // classification on the updated state, first matching reason wins
  // ---------------------------------------------------------------------
  assign first = head_d[0];

  // space, tab, line feed, carriage return, form feed, vertical tab
  assign first_ws = (first == 8'h20) || (first == 8'h09) || (first == 8'h0a) ||
                    (first == 8'h0d) || (first == 8'h0c) || (first == 8'h0b);
  assign last_ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) ||
                    (b == 8'h0d) || (b == 8'h0c) || (b == 8'h0b);

  assign first_ind = (first == "?") || (first == "-") || (first == "*") ||
                     (first == "&") || (first == "!") || (first == "|") ||
                     (first == ">") || (first == "%") || (first == "@");

  assign first_sign = (first == "+") || (first == "-");

  // reserved words, compared on the case-folded head
  assign is_word =
      ((cnt_d == 3'd4) && (head_d[0] == "n") && (head_d[1] == "u") &&
       (head_d[2] == "l") && (head_d[3] == "l")) ||
      ((cnt_d == 3'd4) && (head_d[0] == "t") && (head_d[1] == "r") &&
       (head_d[2] == "u") && (head_d[3] == "e")) ||
      ((cnt_d == 3'd5) && (head_d[0] == "f") && (head_d[1] == "a") &&
       (head_d[2] == "l") && (head_d[3] == "s") && (head_d[4] == "e")) ||
      ((cnt_d == 3'd3) && (head_d[0] == "y") && (head_d[1] == "e") &&
       (head_d[2] == "s")) ||
      ((cnt_d == 3'd2) && (head_d[0] == "n") && (head_d[1] == "o")) ||
      ((cnt_d == 3'd2) && (head_d[0] == "o") && (head_d[1] == "n")) ||
      ((cnt_d == 3'd3) && (head_d[0] == "o") && (head_d[1] == "f") &&
       (head_d[2] == "f"));

  // .inf, .nan, and a signed .inf
  assign is_special_num =
      ((cnt_d == 3'd4) && (head_d[0] == ".") && (head_d[1] == "i") &&
       (head_d[2] == "n") && (head_d[3] == "f")) ||
      ((cnt_d == 3'd4) && (head_d[0] == ".") && (head_d[1] == "n") &&
       (head_d[2] == "a") && (head_d[3] == "n")) ||
      ((cnt_d == 3'd5) && first_sign && (head_d[1] == ".") && (head_d[2] == "i") &&
       (head_d[3] == "n") && (head_d[4] == "f"));

  always_comb begin
    if (in_q.empty_scalar)                          reason = ysq_pkg::REASON_EMPTY;
    else if (break_d)                               reason = ysq_pkg::REASON_BREAK;
    else if (first_ws || last_ws)                   reason = ysq_pkg::REASON_EDGE_SPACE;
    else if (first_ind)                             reason = ysq_pkg::REASON_INDICATOR;
    else if (colon_d)                               reason = ysq_pkg::REASON_COLON_SPACE;
    else if ((cnt_d == 3'd1) && (first == "~"))     reason = ysq_pkg::REASON_TILDE;
    else if (is_word)                               reason = ysq_pkg::REASON_WORD;
    else if (is_special_num || num_status.accepting) reason = ysq_pkg::REASON_NUMERIC;
    else                                            reason = ysq_pkg::REASON_PLAIN;
  end

  // ---------------------------------------------------------------------
  // state registers: cleared after every end of scalar
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= 3'd0;
      prev_q  <= 8'd0;
      break_q <= 1'b0;
      colon_q <= 1'b0;
      num_q   <= ysq_pkg::NS_START;
    end else if (advance) begin
      if (produces) begin
        head_q  <= '0;
        cnt_q   <= 3'd0;
        prev_q  <= 8'd0;
        break_q <= 1'b0;
        colon_q <= 1'b0;
        num_q   <= ysq_pkg::NS_START;
      end else begin
        head_q  <= head_d;
        cnt_q   <= cnt_d;
        prev_q  <= b;
        break_q <= break_d;
        colon_q <= colon_d;
        num_q   <= num_status.next_state;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produces) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_q.needs_quote <= (reason != ysq_pkg::REASON_PLAIN);
      out_q.reason      <= reason;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a result never overwrites one still held by the receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && produces && out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // the scalar state is empty after an end of scalar
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && produces) |=> (cnt_q == 3'd0) && (num_q == ysq_pkg::NS_START))
    else $error("scalar state not cleared after result");

  // the length counter saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ysq_pkg::CNT_MAX)
    else $error("length counter past saturation");

  // stall only when an item is actually held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && produces && out_valid_q)
    else $error("input stalled without a blocked result");

endmodule

// ----- sv/ysq_num_fsm.sv -----
// next-state logic of the yaml numeric literal recognizer
// depends on ysq_pkg
module ysq_num_fsm (
  input  logic [ysq_pkg::NUM_W-1:0] state_i,
  input  logic [7:0]                char_i,
  output ysq_pkg::num_status_t      status_o
);

  logic [7:0]                f;
  logic                      is_dig;
  logic                      is_hex;
  logic                      is_oct;
  logic                      is_sign;
  logic [ysq_pkg::NUM_W-1:0] nxt;

  assign f       = ysq_pkg::fold(char_i);
  assign is_dig  = (char_i >= "0") && (char_i <= "9");
  assign is_hex  = is_dig || ((f >= "a") && (f <= "f"));
  assign is_oct  = (char_i >= "0") && (char_i <= "7");
  assign is_sign = (char_i == "+") || (char_i == "-");

  always_comb begin
    nxt = ysq_pkg::NS_DEAD;
    case (state_i)
      ysq_pkg::NS_START: begin
        if (char_i == "0")     nxt = ysq_pkg::NS_ZERO;
        else if (is_dig)       nxt = ysq_pkg::NS_INT;
        else if (is_sign)      nxt = ysq_pkg::NS_SIGN;
        else if (char_i == ".") nxt = ysq_pkg::NS_DOTONLY;
      end
      ysq_pkg::NS_SIGN: begin
        if (is_dig)            nxt = ysq_pkg::NS_INT;
        else if (char_i == ".") nxt = ysq_pkg::NS_DOTONLY;
      end
      ysq_pkg::NS_ZERO, ysq_pkg::NS_INT: begin
        // a leading zero may open a hex or octal prefix
        if (state_i == ysq_pkg::NS_ZERO && f == "x")      nxt = ysq_pkg::NS_HEXPRE;
        else if (state_i == ysq_pkg::NS_ZERO && f == "o") nxt = ysq_pkg::NS_OCTPRE;
        else if (is_dig)                                  nxt = ysq_pkg::NS_INT;
        else if (char_i == ".")                           nxt = ysq_pkg::NS_FRAC;
        else if (f == "e")                                nxt = ysq_pkg::NS_EXPE;
      end
      ysq_pkg::NS_DOTONLY: begin
        if (is_dig) nxt = ysq_pkg::NS_FRAC;
      end
      ysq_pkg::NS_FRAC: begin
        if (is_dig)        nxt = ysq_pkg::NS_FRAC;
        else if (f == "e") nxt = ysq_pkg::NS_EXPE;
      end
      ysq_pkg::NS_EXPE: begin
        if (is_sign)     nxt = ysq_pkg::NS_EXPSIGN;
        else if (is_dig) nxt = ysq_pkg::NS_EXPDIG;
      end
      ysq_pkg::NS_EXPSIGN, ysq_pkg::NS_EXPDIG: begin
        if (is_dig) nxt = ysq_pkg::NS_EXPDIG;
      end
      ysq_pkg::NS_HEXPRE, ysq_pkg::NS_HEX: begin
        if (is_hex) nxt = ysq_pkg::NS_HEX;
      end
      ysq_pkg::NS_OCTPRE, ysq_pkg::NS_OCT: begin
        if (is_oct) nxt = ysq_pkg::NS_OCT;
      end
      default: nxt = ysq_pkg::NS_DEAD;
    endcase
  end

  assign status_o.next_state = nxt;
  assign status_o.accepting  = (nxt == ysq_pkg::NS_ZERO)   || (nxt == ysq_pkg::NS_INT) ||
                               (nxt == ysq_pkg::NS_FRAC)   || (nxt == ysq_pkg::NS_EXPE) ||
                               (nxt == ysq_pkg::NS_EXPDIG) || (nxt == ysq_pkg::NS_HEX) ||
                               (nxt == ysq_pkg::NS_OCT);

endmodule
